[rtl/u2u_pkg.sv]
// Shared types and constants for the UTF-8 to 16-bit unit decoder.
// Used by u2u_dec, u2u_ofifo and utf8_to_utf16_decoder; depends on nothing.
package u2u_pkg;

  localparam int unsigned CAP_W   = 16;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned ACC_W   = 21;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APPEND_TERM  = 2'd1;

  typedef enum logic [1:0] {
    KIND_UNIT       = 2'd0,
    KIND_END_TERM   = 2'd1,
    KIND_END_NOTERM = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [CAP_W-1:0] out_capacity;
    logic             append_terminator;
  } cfg_t;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    kind_t             kind;
    logic              last;
    logic [CAP_W-1:0]  units_written;
  } result_t;

endpackage

[rtl/u2u_dec.sv]
// Decode step: sequence state registers and the per-byte next-state and result logic.
// Depends on u2u_pkg.
module u2u_dec (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  u2u_pkg::item_t    item,
  input  u2u_pkg::cfg_t     cfg,
  output u2u_pkg::result_t  res_a,
  output u2u_pkg::result_t  res_b,
  output logic [1:0]        push_n
);
  import u2u_pkg::*;

  logic             halted;
  logic [1:0]       bytes_left;
  logic [ACC_W-1:0] accumulator;
  logic             still_accumulating;
  logic [CAP_W-1:0] written_count;

  logic             halted_next;
  logic [1:0]       bytes_left_next;
  logic [ACC_W-1:0] accumulator_next;
  logic             still_accumulating_next;
  logic [CAP_W-1:0] written_count_next;

  logic              want_unit;
  logic              emit_unit;
  logic [UNIT_W-1:0] unit_val;
  logic [CAP_W-1:0]  cap_eff;
  logic [7:0]        b;
  result_t           unit_res;
  result_t           end_res;

  assign b = item.in_byte;

  always_comb begin
    if (cfg.append_terminator) begin
      cap_eff = (cfg.out_capacity == '0) ? '0 : cfg.out_capacity - CAP_W'(1);
    end else begin
      cap_eff = cfg.out_capacity;
    end
  end

  always_comb begin
    halted_next             = halted;
    bytes_left_next         = bytes_left;
    accumulator_next        = accumulator;
    still_accumulating_next = still_accumulating;
    written_count_next      = written_count;
    want_unit               = 1'b0;
    emit_unit               = 1'b0;
    unit_val                = '0;

    if (item.has_byte && !halted) begin
      if (bytes_left != 2'd0) begin
        // payload bits only until the first byte that is not 10xxxxxx
        if (still_accumulating && b[7:6] == 2'b10) begin
          accumulator_next = {accumulator[ACC_W-7:0], b[5:0]};
        end else begin
          still_accumulating_next = 1'b0;
        end
        bytes_left_next = bytes_left - 2'd1;
        if (bytes_left_next == 2'd0) begin
          still_accumulating_next = 1'b0;
          want_unit = 1'b1;
          unit_val  = accumulator_next[UNIT_W-1:0];
        end
      end else if (!b[7]) begin
        want_unit = 1'b1;
        unit_val  = {8'h00, b};
      end else if (b[7:5] == 3'b110) begin
        accumulator_next        = {16'd0, b[4:0]};
        bytes_left_next         = 2'd1;
        still_accumulating_next = 1'b1;
      end else if (b[7:4] == 4'b1110) begin
        accumulator_next        = {17'd0, b[3:0]};
        bytes_left_next         = 2'd2;
        still_accumulating_next = 1'b1;
      end else if (b[7:3] == 5'b11110) begin
        accumulator_next        = {18'd0, b[2:0]};
        bytes_left_next         = 2'd3;
        still_accumulating_next = 1'b1;
      end else begin
        halted_next = 1'b1;
      end
    end

    // string ends inside a sequence: flush the partial codepoint
    if (item.end_of_string && bytes_left_next != 2'd0 && !halted_next) begin
      want_unit = 1'b1;
      unit_val  = accumulator_next[UNIT_W-1:0];
    end

    if (want_unit && !halted_next) begin
      if (written_count >= cap_eff) begin
        halted_next = 1'b1;
      end else begin
        emit_unit          = 1'b1;
        written_count_next = written_count + CAP_W'(1);
      end
    end

    unit_res.code_unit     = unit_val;
    unit_res.kind          = KIND_UNIT;
    unit_res.last          = 1'b0;
    unit_res.units_written = '0;

    end_res.code_unit      = '0;
    end_res.kind           = (cfg.append_terminator && cfg.out_capacity != '0) ?
                             KIND_END_TERM : KIND_END_NOTERM;
    end_res.last           = 1'b1;
    end_res.units_written  = written_count_next;

    // drop all stream state after the end word
    if (item.end_of_string) begin
      halted_next             = 1'b0;
      bytes_left_next         = 2'd0;
      accumulator_next        = '0;
      still_accumulating_next = 1'b0;
      written_count_next      = '0;
    end
  end

  assign res_a  = emit_unit ? unit_res : end_res;
  assign res_b  = end_res;
  assign push_n = advance ? ({1'b0, emit_unit} + {1'b0, item.end_of_string}) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      halted             <= 1'b0;
      bytes_left         <= 2'd0;
      accumulator        <= '0;
      still_accumulating <= 1'b0;
      written_count      <= '0;
    end else if (advance) begin
      halted             <= halted_next;
      bytes_left         <= bytes_left_next;
      accumulator        <= accumulator_next;
      still_accumulating <= still_accumulating_next;
      written_count      <= written_count_next;
    end
  end

endmodule

[rtl/u2u_ofifo.sv]
// Result queue: takes up to two words per cycle, hands out one per cycle on pop.
// Depends on u2u_pkg.
module u2u_ofifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  push_n,
  input  u2u_pkg::result_t            res_a,
  input  u2u_pkg::result_t            res_b,
  input  logic                        pop,
  output u2u_pkg::result_t            head,
  output logic [u2u_pkg::OQ_CW-1:0]   count
);
  import u2u_pkg::*;

  result_t          slots [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_AW-1:0] wr_ptr_b;
  logic             do_pop;

  assign do_pop   = pop && (count != '0);
  assign wr_ptr_b = wr_ptr + OQ_AW'(1);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[wr_ptr] <= res_a;
    end
    if (push_n == 2'd2) begin
      slots[wr_ptr_b] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(push_n);
      if (do_pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      count <= count + OQ_CW'(push_n) - OQ_CW'(do_pop);
    end
  end

endmodule

[rtl/utf8_to_utf16_decoder.sv]
// Top level of the UTF-8 to 16-bit unit decoder: ports, input register, config registers.
// Depends on u2u_pkg, u2u_dec and u2u_ofifo.
//
//  channel  signals                          word
//  s_*      s_tvalid s_tready s_tdata ...    one string byte or end-only marker
//  m_*      m_tvalid m_tready m_tdata ...    one decoded unit or end record
//  cfg_*    cfg_valid cfg_ready cfg_index    register write, always taken
//
// One byte per cycle while the result queue has room: a byte is held in the input register,
// then the decode step writes zero, one or two words into a four-entry result queue.
// The input register and the result queue lie between input accept and the first output word.
// The input register advances only when the queue has room for two words, so a
// stalled m_tready backs up into s_tready after a few words.
// Synchronous reset clears decode state and queue pointers and resets the config registers.
module utf8_to_utf16_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] in_byte
  input  logic [0:0]                      s_tuser,   // [0] has_byte
  input  logic                            s_tlast,   // end_of_string
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [15:0] code_unit, [31:16] units_written
  output logic [1:0]                      m_tuser,   // [1:0] kind
  output logic                            m_tlast,   // last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [u2u_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);
  import u2u_pkg::*;

  cfg_t             cfg;
  item_t            item;
  logic             in_valid;
  logic             advance;
  logic [1:0]       push_n;
  result_t          res_a;
  result_t          res_b;
  result_t          head;
  logic [OQ_CW-1:0] oq_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_capacity      <= 16'hFFFF;
      cfg.append_terminator <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OUT_CAPACITY: cfg.out_capacity      <= cfg_data;
        CFG_APPEND_TERM:  cfg.append_terminator <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance only with room for a unit plus an end word
  assign advance  = in_valid && (oq_count <= OQ_CW'(OQ_DEPTH - 2));
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.in_byte       <= s_tdata;
      item.has_byte      <= s_tuser[0];
      item.end_of_string <= s_tlast;
    end
  end

  u2u_dec u_dec (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .res_a   (res_a),
    .res_b   (res_b),
    .push_n  (push_n)
  );

  u2u_ofifo u_ofifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .res_a  (res_a),
    .res_b  (res_b),
    .pop    (m_tready),
    .head   (head),
    .count  (oq_count)
  );

  assign m_tvalid = (oq_count != '0);
  assign m_tdata  = {head.units_written, head.code_unit};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  a_room_on_advance: assert property (@(posedge clk) disable iff (rst)
    advance |-> oq_count <= OQ_CW'(OQ_DEPTH - 2))
    else $error("decode advanced without room for two words");

  a_pair_is_end: assert property (@(posedge clk) disable iff (rst)
    push_n == 2'd2 |-> item.end_of_string && !res_a.last && res_b.last)
    else $error("two words pushed for an item that does not end the string");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser != KIND_UNIT)
    else $error("end word carries a unit kind");

  a_unit_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == KIND_UNIT && m_tdata[31:16] == 16'h0000)
    else $error("unit word carries end fields");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= OQ_CW'(OQ_DEPTH))
    else $error("result queue overflow");

endmodule

[dv/tb.sv]
// Self-checking bench for utf8_to_utf16_decoder: feeds UTF-8 strings one byte per word,
// predicts every unit and end word in a small tracker class and checks them in order.
// Depends on u2u_pkg and the decoder RTL.
module tb;
  import u2u_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned DRAIN_CYCLES = 8;

  class unit_tracker;
    bit [CAP_W-1:0] capacity;
    bit             add_term;
    bit             stopped;
    bit [1:0]       cont_left;
    bit [ACC_W-1:0] code_acc;
    bit             gathering;
    bit [CAP_W-1:0] units_out;
    result_t        due_words[$];
    int             errors;

    function new();
      capacity = '1;
      add_term = 1'b0;
      errors   = 0;
      clear_string();
    endfunction

    function void clear_string();
      stopped   = 1'b0;
      cont_left = '0;
      code_acc  = '0;
      gathering = 1'b0;
      units_out = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_OUT_CAPACITY: capacity = val;
        CFG_APPEND_TERM:  add_term = val[0];
        default: ;
      endcase
    endfunction

    // Room for decoded units; the terminator takes one slot when enabled.
    function bit [CAP_W-1:0] room();
      if (add_term) return (capacity == '0) ? '0 : capacity - 1'b1;
      return capacity;
    endfunction

    function void push_word(bit [UNIT_W-1:0] cu, kind_t k, bit lst, bit [CAP_W-1:0] cnt);
      result_t w;
      w.code_unit     = cu;
      w.kind          = k;
      w.last          = lst;
      w.units_written = cnt;
      due_words.push_back(w);
    endfunction

    function void put_unit(bit [ACC_W-1:0] cp);
      if (stopped) return;
      if (units_out >= room()) begin
        stopped = 1'b1;
        return;
      end
      push_word(cp[UNIT_W-1:0], KIND_UNIT, 1'b0, '0);
      units_out++;
    endfunction

    function void take_item(bit [7:0] octet, bit has, bit eos);
      kind_t k;
      if (has && !stopped) begin
        if (cont_left != 0) begin
          // Payload stops at the first byte that is not 10xxxxxx; the slot still counts.
          if (gathering && octet[7:6] == 2'b10)
            code_acc = {code_acc[ACC_W-7:0], octet[5:0]};
          else
            gathering = 1'b0;
          cont_left--;
          if (cont_left == 0) begin
            gathering = 1'b0;
            put_unit(code_acc);
          end
        end else if (!octet[7]) begin
          put_unit({13'd0, octet});
        end else if (octet[7:5] == 3'b110) begin
          code_acc  = {16'd0, octet[4:0]};
          cont_left = 2'd1;
          gathering = 1'b1;
        end else if (octet[7:4] == 4'b1110) begin
          code_acc  = {17'd0, octet[3:0]};
          cont_left = 2'd2;
          gathering = 1'b1;
        end else if (octet[7:3] == 5'b11110) begin
          code_acc  = {18'd0, octet[2:0]};
          cont_left = 2'd3;
          gathering = 1'b1;
        end else begin
          stopped = 1'b1;
        end
      end
      if (eos) begin
        // Flush a sequence cut short by the end of the string.
        if (cont_left != 0 && !stopped) put_unit(code_acc);
        k = (add_term && capacity != '0) ? KIND_END_TERM : KIND_END_NOTERM;
        push_word('0, k, 1'b1, units_out);
        clear_string();
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(result_t got);
      result_t want;
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word unit=%h kind=%0d last=%0b count=%0d",
                         got.code_unit, got.kind, got.last, got.units_written));
        return;
      end
      want = due_words.pop_front();
      if (got.code_unit !== want.code_unit)
        report($sformatf("code_unit %h, want %h", got.code_unit, want.code_unit));
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
      if (got.units_written !== want.units_written)
        report($sformatf("units_written %0d, want %0d", got.units_written,
                         want.units_written));
    endtask

    function int pending();
      return due_words.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic [7:0]           s_tdata   = '0;
  logic [0:0]           s_tuser   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OUT_CAPACITY;
  logic [15:0]          cfg_data  = '0;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [31:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_ready;

  unit_tracker sb;
  int          send_run     = 0;
  int          recv_run     = 0;
  int          sent_items   = 0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  utf8_to_utf16_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort when no channel has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Gap before the next word: usually drawn at random, now and then a run of words with no gaps.
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  task automatic send_item(input logic [7:0] octet, input logic has, input logic eos);
    int gap;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= octet;
    s_tuser[0] <= has;
    s_tlast    <= eos;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.take_item(octet, has, eos);
    if (has || eos) sent_items++;
  endtask

  function automatic logic [7:0] cont_byte(bit noisy);
    if (noisy && $urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // One string of 0..10 characters; a noisy one carries stray bytes and cut sequences.
  task automatic send_string(bit noisy);
    logic [7:0] octets[$];
    int         nchars;
    int         sel;
    int         ncont;
    logic [7:0] lead;
    bit         end_marker;
    nchars = $urandom_range(0, 10);
    for (int i = 0; i < nchars; i++) begin
      sel = $urandom_range(0, noisy ? 10 : 8);
      if (sel <= 3) begin
        octets.push_back(8'($urandom_range(0, 127)));
      end else if (sel <= 8) begin
        ncont = (sel <= 5) ? 1 : (sel <= 7) ? 2 : 3;
        case (ncont)
          1:       lead = 8'hC0 | 8'($urandom_range(0, 31));
          2:       lead = 8'hE0 | 8'($urandom_range(0, 15));
          default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        octets.push_back(lead);
        repeat (ncont) octets.push_back(cont_byte(noisy));
      end else if (sel == 9) begin
        octets.push_back(8'($urandom_range(0, 255)));
      end else begin
        // lone lead: cut off by the next character or by the end of the string
        octets.push_back(8'($urandom_range(8'hC0, 8'hF7)));
      end
    end
    end_marker = (octets.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (octets[i]) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(octets[i], 1'b1, !end_marker && (i == octets.size() - 1));
    end
    if (end_marker) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Drop valid, wait for every due word, then let the pipeline empty.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] cap, input logic term);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OUT_CAPACITY;
    cfg_data  <= cap;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(CFG_OUT_CAPACITY, cap);
    cfg_index <= CFG_APPEND_TERM;
    cfg_data  <= {15'd0, term};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(CFG_APPEND_TERM, {15'd0, term});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    result_t got;
    int      gap;
    wait (rst === 1'b0);
    forever begin
      // Long hold-off: the block must fill its queue and stall the input side.
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap(recv_run);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got.code_unit     = m_tdata[15:0];
      got.units_written = m_tdata[31:16];
      got.kind          = kind_t'(m_tuser);
      got.last          = m_tlast;
      sb.check_word(got);
    end
  end

  initial begin
    int          phase;
    int          phase_end;
    logic [15:0] cap;
    logic        term;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ascii extremes, an empty word, 2/3/4-byte sequences, end-only marker
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hC3, 1'b1, 1'b0);
    send_item(8'hA9, 1'b1, 1'b0);
    send_item(8'hE2, 1'b1, 1'b0);
    send_item(8'h82, 1'b1, 1'b0);
    send_item(8'hAC, 1'b1, 1'b0);
    send_item(8'hF0, 1'b1, 1'b0);
    send_item(8'h9F, 1'b1, 1'b0);
    send_item(8'h98, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // continuation byte in lead position halts the string
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b1);
    // broken continuation, then a sequence cut by the end of the string
    send_item(8'hC3, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'hE2, 1'b1, 1'b0);
    send_item(8'h82, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hBF, 1'b1, 1'b1);
    send_item(8'h41, 1'b1, 1'b1);

    sent_items = 0;
    phase = 0;
    while (sent_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin cap = 16'hFFFF; term = 1'b0; end
        1: begin cap = 16'hFFFF; term = 1'b1; end
        2: begin cap = 16'd0;    term = 1'b0; end
        3: begin cap = 16'd0;    term = 1'b1; end
        4: begin cap = 16'd1;    term = 1'b1; end
        5: begin cap = 16'd1;    term = 1'b0; end
        6: begin cap = 16'd2;    term = 1'b1; end
        default: begin
          cap  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                               16'($urandom_range(0, 12));
          term = 1'($urandom_range(0, 1));
        end
      endcase
      quiesce();
      set_regs(cap, term);
      if (phase == 1) hold_request = 1'b1;
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end && sent_items < RANDOM_ITEMS)
        send_string($urandom_range(0, 3) == 0);
      phase++;
    end

    quiesce();
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/u2u_pkg.sv
rtl/u2u_dec.sv
rtl/u2u_ofifo.sv
rtl/utf8_to_utf16_decoder.sv
dv/tb.sv
